>>> design/hflp_pkg.sv
// Shared types and constants for the hex float literal parser.
`default_nettype none

package hflp_pkg;

    // One character of the literal.
    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_in_req;

    // One parsed binary32 value.
    typedef struct packed {
        logic [31:0] float_bits;
        logic        overflowed;
    } t_out_req;

    // Character codes.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UP    = 8'h50;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LP    = 8'h70;

    // One hex digit is four mantissa bits; exponent digits are decimal.
    localparam int         DIGIT_BITS = 4;
    localparam int         DEC_RADIX  = 10;
    localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

    // Digit counters saturate at their all-ones value.
    localparam int               CNT_W     = 12;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // binary32 format.
    localparam int          FRAC_BITS    = 23;
    localparam int          EXP_BIAS     = 127;
    localparam int          MAX_EXP      = 127;
    localparam int          MIN_NORM_EXP = -126;
    localparam int          MIN_QUANTUM  = -149;
    localparam int          EXP_FIELD_MAX = 255;
    localparam logic [31:0] INF_BITS     = 32'h7F80_0000;

endpackage

`default_nettype wire

>>> design/hex_float_literal_parser_top.sv
// Top level of the hex float literal parser: character parser and encoder pipeline.
//
// Takes one ASCII character per request and, on the request marked is_last,
// produces one binary32 value (sign always zero), rounded to nearest even;
// a value beyond the binary32 range returns infinity with overflowed set.
// Leading spaces are skipped and the next two characters are taken as the
// prefix unchecked. Hex digits then fill a MANTISSA_WIDTH-bit accumulator,
// '.' starts the fraction and 'p' or 'P' the exponent, which takes an
// optional sign and decimal digits saturating at EXPONENT_LIMIT. Characters
// that fit nowhere are ignored. A new character is accepted every cycle unless
// input ready is low; the parser state updates in the cycle of acceptance. The
// edge that accepts the last character loads the snapshot stage, and the value
// then passes exponent sum and leading one, shift amount, alignment, and
// rounding into the output register, which drives o_out_valid.
// Backpressure on the output stalls the encoder pipeline stage by stage, and
// input ready drops only once that pipeline is full.
`default_nettype none

module hex_float_literal_parser_top
    import hflp_pkg::*;
#(
    parameter int MANTISSA_WIDTH = 64,
    parameter int EXPONENT_LIMIT = 9999
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output      logic     o_in_ready,
    input  wire t_in_req  i_in_req,
    output      logic     o_out_valid,
    input  wire logic     i_out_ready,
    output      t_out_req o_out_req
);

    localparam int MW    = MANTISSA_WIDTH;
    localparam int EXP_W = $clog2(EXPONENT_LIMIT + 1);
    localparam int EV_W  = EXP_W + 4;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_PREFIX,
        PH_INT,
        PH_FRAC,
        PH_EXP_START,
        PH_EXP_DIGITS
    } t_phase;

    // Parser state.
    t_phase           r_phase,   n_phase;
    logic [MW-1:0]    r_acc,     n_acc;
    logic             r_sticky,  n_sticky;
    logic [CNT_W-1:0] r_frac,    n_frac;
    logic [CNT_W-1:0] r_dropped, n_dropped;
    logic [EXP_W-1:0] r_exp,     n_exp;
    logic             r_neg,     n_neg;

    logic       w_accept;
    logic       w_enc_ready;
    logic [7:0] w_c;
    logic       w_hex_ok;
    logic [3:0] w_hex;
    logic       w_dec_ok;
    logic       w_is_p;
    logic       w_acc_full;
    logic       w_is_frac;
    logic [EV_W-1:0] w_ev;

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = w_enc_ready;
    assign w_c        = i_in_req.char_code;
    assign w_is_p     = (w_c == CH_LP) || (w_c == CH_UP);
    assign w_dec_ok   = w_c inside {[CH_0:CH_9]};
    assign w_acc_full = |r_acc[MW-1 -: DIGIT_BITS];
    assign w_is_frac  = (r_phase == PH_FRAC);

    // Hex digit decode: letters map to ten through fifteen.
    always_comb begin
        w_hex_ok = 1'b1;
        w_hex    = '0;
        if (w_c inside {[CH_0:CH_9]}) begin
            w_hex = 4'(w_c - CH_0);
        end else if (w_c inside {[CH_LA:CH_LF]}) begin
            w_hex = 4'(w_c - CH_LA) + HEX_LETTER_BASE;
        end else if (w_c inside {[CH_UA:CH_UF]}) begin
            w_hex = 4'(w_c - CH_UA) + HEX_LETTER_BASE;
        end else begin
            w_hex_ok = 1'b0;
        end
    end

    // Decimal exponent: multiply-accumulate, saturate at the limit.
    assign w_ev = EV_W'(r_exp) * EV_W'(DEC_RADIX) + EV_W'(w_c - CH_0);

    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_sticky  = r_sticky;
        n_frac    = r_frac;
        n_dropped = r_dropped;
        n_exp     = r_exp;
        n_neg     = r_neg;
        case (r_phase)
            PH_SPACE: begin
                if (w_c != CH_SPACE) n_phase = PH_PREFIX;
            end
            PH_PREFIX: begin
                n_phase = PH_INT;
            end
            PH_INT, PH_FRAC: begin
                if (r_phase == PH_INT && w_c == CH_DOT) begin
                    n_phase = PH_FRAC;
                end else if (w_is_p) begin
                    n_phase = PH_EXP_START;
                end else if (w_hex_ok) begin
                    if (!w_acc_full) begin
                        // shift the digit in
                        n_acc = {r_acc[MW-DIGIT_BITS-1:0], w_hex};
                        if (w_is_frac && r_frac != COUNT_MAX) n_frac = r_frac + 1'b1;
                    end else begin
                        // drop the digit, keep only its weight and stickiness
                        if (w_hex != '0) n_sticky = 1'b1;
                        if (!w_is_frac && r_dropped != COUNT_MAX) begin
                            n_dropped = r_dropped + 1'b1;
                        end
                    end
                end
            end
            PH_EXP_START, PH_EXP_DIGITS: begin
                if (r_phase == PH_EXP_START && (w_c == CH_MINUS || w_c == CH_PLUS)) begin
                    n_neg   = (w_c == CH_MINUS);
                    n_phase = PH_EXP_DIGITS;
                end else if (w_dec_ok) begin
                    n_exp   = (w_ev > EV_W'(EXPONENT_LIMIT)) ? EXP_W'(EXPONENT_LIMIT)
                                                              : w_ev[EXP_W-1:0];
                    n_phase = PH_EXP_DIGITS;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Hold state between characters; clear it after the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SPACE;
            r_acc     <= '0;
            r_sticky  <= 1'b0;
            r_frac    <= '0;
            r_dropped <= '0;
            r_exp     <= '0;
            r_neg     <= 1'b0;
        end else if (w_accept) begin
            if (i_in_req.is_last) begin
                r_phase   <= PH_SPACE;
                r_acc     <= '0;
                r_sticky  <= 1'b0;
                r_frac    <= '0;
                r_dropped <= '0;
                r_exp     <= '0;
                r_neg     <= 1'b0;
            end else begin
                r_phase   <= n_phase;
                r_acc     <= n_acc;
                r_sticky  <= n_sticky;
                r_frac    <= n_frac;
                r_dropped <= n_dropped;
                r_exp     <= n_exp;
                r_neg     <= n_neg;
            end
        end
    end

    // The encoder snapshots the state as updated by the last character.
    hflp_encode #(
        .MW    (MW),
        .EXP_W (EXP_W)
    ) u_encode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_accept && i_in_req.is_last),
        .o_ready   (w_enc_ready),
        .i_acc     (n_acc),
        .i_sticky  (n_sticky),
        .i_exp_mag (n_exp),
        .i_exp_neg (n_neg),
        .i_dropped (n_dropped),
        .i_frac    (n_frac),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_req     (o_out_req)
    );

endmodule

`default_nettype wire

>>> design/hflp_encode.sv
// Five-stage pipeline that turns a parsed mantissa and exponent into binary32.
`default_nettype none

module hflp_encode
    import hflp_pkg::*;
#(
    parameter int MW    = 64,
    parameter int EXP_W = 14
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output      logic             o_ready,
    input  wire logic [MW-1:0]    i_acc,
    input  wire logic             i_sticky,
    input  wire logic [EXP_W-1:0] i_exp_mag,
    input  wire logic             i_exp_neg,
    input  wire logic [CNT_W-1:0] i_dropped,
    input  wire logic [CNT_W-1:0] i_frac,
    output      logic             o_valid,
    input  wire logic             i_ready,
    output      t_out_req         o_req
);

    localparam int CNT4_W = CNT_W + 2;
    localparam int MAG_W  = (EXP_W > CNT4_W) ? EXP_W : CNT4_W;
    localparam int E_W    = MAG_W + 2;
    localparam int SW     = E_W + 1;
    localparam int M_W    = $clog2(MW);
    localparam int SH_W   = $clog2(MW + 2);
    localparam int KEEP_W = FRAC_BITS + 1;
    localparam int LS_W   = $clog2(KEEP_W);

    localparam logic signed [SW-1:0] L_MIN_NORM = SW'(MIN_NORM_EXP);
    localparam logic signed [SW-1:0] L_MIN_Q    = SW'(MIN_QUANTUM);
    localparam logic signed [SW-1:0] L_MAX_EXP  = SW'(MAX_EXP);
    localparam logic signed [SW-1:0] L_FRAC     = SW'(FRAC_BITS);
    localparam logic signed [SW-1:0] L_BIAS     = SW'(EXP_BIAS);
    localparam logic signed [SW-1:0] L_FLD_MAX  = SW'(EXP_FIELD_MAX);
    localparam logic signed [SW-1:0] L_SH_MAX   = SW'(MW + 1);

    // stage advance chain
    logic w_adv1, w_adv2, w_adv3, w_adv4, w_adv5;

    // stage 1: snapshot
    logic             r1_valid;
    logic [MW-1:0]    r1_acc;
    logic             r1_sticky;
    logic [EXP_W-1:0] r1_exp_mag;
    logic             r1_exp_neg;
    logic [CNT_W-1:0] r1_dropped;
    logic [CNT_W-1:0] r1_frac;

    // stage 2: exponent sum and leading one
    logic                  r2_valid;
    logic [MW-1:0]         r2_acc;
    logic                  r2_sticky;
    logic signed [E_W-1:0] r2_e;
    logic [M_W-1:0]        r2_m;
    logic                  r2_zero;
    logic signed [E_W-1:0] w_mag, w_drop4, w_frac4, w_e;
    logic [M_W-1:0]        w_m;

    // stage 3: shift amount and range check
    logic                 r3_valid;
    logic [MW-1:0]        r3_acc;
    logic                 r3_sticky;
    logic signed [SW-1:0] r3_s;
    logic signed [SW-1:0] r3_ue;
    logic                 r3_sub;
    logic                 r3_ovf;
    logic                 r3_zero;
    logic signed [SW-1:0] w_e3, w_m3, w_ue, w_s;
    logic                 w_sub;

    // stage 4: aligned significand
    logic                 r4_valid;
    logic [KEEP_W-1:0]    r4_kept;
    logic                 r4_rbit;
    logic                 r4_st;
    logic signed [SW-1:0] r4_ue;
    logic                 r4_sub;
    logic                 r4_ovf;
    logic                 r4_zero;
    logic [LS_W-1:0]      w_ls;
    logic [SH_W-1:0]      w_sh;
    logic [MW-1:0]        w_lshift;
    logic [MW:0]          w_x, w_y, w_lost;
    logic [KEEP_W-1:0]    w_kept;
    logic                 w_rbit, w_st;
    logic signed [SW-1:0] w_neg_s;

    // stage 5: rounded result
    logic                 r5_valid;
    t_out_req             r5_req;
    logic                 w_inc, w_carry;
    logic [KEEP_W:0]      w_k;
    logic signed [SW-1:0] w_biased;
    logic [FRAC_BITS-1:0] w_fbits;
    t_out_req             w_res;

    assign w_adv5  = !r5_valid || i_ready;
    assign w_adv4  = !r4_valid || w_adv5;
    assign w_adv3  = !r3_valid || w_adv4;
    assign w_adv2  = !r2_valid || w_adv3;
    assign w_adv1  = !r1_valid || w_adv2;
    assign o_ready = w_adv1;

    // ---- stage 2 logic
    assign w_mag   = signed'(E_W'(r1_exp_mag));
    assign w_drop4 = signed'(E_W'({r1_dropped, 2'b00}));
    assign w_frac4 = signed'(E_W'({r1_frac, 2'b00}));
    assign w_e     = (r1_exp_neg ? -w_mag : w_mag) + w_drop4 - w_frac4;

    always_comb begin
        w_m = '0;
        for (int i = 0; i < MW; i++) begin
            if (r1_acc[i]) begin
                w_m = M_W'(i);
            end
        end
    end

    // ---- stage 3 logic
    assign w_e3  = SW'(r2_e);
    assign w_m3  = signed'(SW'(r2_m));
    assign w_ue  = w_m3 + w_e3;
    assign w_sub = (w_ue <= L_MIN_NORM);
    assign w_s   = w_sub ? (L_MIN_Q - w_e3) : (w_m3 - L_FRAC);

    // ---- stage 4 logic
    assign w_neg_s  = -r3_s;
    assign w_ls     = w_neg_s[LS_W-1:0];
    assign w_sh     = (r3_s > L_SH_MAX) ? SH_W'(MW + 1) : r3_s[SH_W-1:0];
    assign w_lshift = r3_acc << w_ls;
    assign w_x      = {r3_acc, 1'b0};
    assign w_y      = w_x >> w_sh;
    assign w_lost   = w_x & ~({(MW + 1){1'b1}} << w_sh);

    always_comb begin
        if (r3_s <= 0) begin
            w_kept = w_lshift[KEEP_W-1:0];
            w_rbit = 1'b0;
            w_st   = r3_sticky;
        end else begin
            w_kept = w_y[KEEP_W:1];
            w_rbit = w_y[0];
            w_st   = r3_sticky || (|w_lost);
        end
    end

    // ---- stage 5 logic
    assign w_inc    = r4_rbit && (r4_st || r4_kept[0]);
    assign w_k      = {1'b0, r4_kept} + (KEEP_W + 1)'(w_inc);
    assign w_carry  = w_k[KEEP_W];
    assign w_biased = r4_ue + L_BIAS + signed'(SW'(w_carry));
    assign w_fbits  = w_carry ? w_k[KEEP_W-1:1] : w_k[FRAC_BITS-1:0];

    always_comb begin
        w_res = '0;
        if (r4_zero) begin
            w_res = '0;
        end else if (r4_ovf) begin
            w_res.float_bits = INF_BITS;
            w_res.overflowed = 1'b1;
        end else if (r4_sub) begin
            w_res.float_bits = 32'(w_k);
        end else if (w_biased >= L_FLD_MAX) begin
            w_res.float_bits = INF_BITS;
            w_res.overflowed = 1'b1;
        end else begin
            w_res.float_bits = {1'b0, w_biased[7:0], w_fbits};
        end
    end

    // ---- pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            if (w_adv1) r1_valid <= i_valid;
            if (w_adv2) r2_valid <= r1_valid;
            if (w_adv3) r3_valid <= r2_valid;
            if (w_adv4) r4_valid <= r3_valid;
            if (w_adv5) r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r1_acc     <= i_acc;
            r1_sticky  <= i_sticky;
            r1_exp_mag <= i_exp_mag;
            r1_exp_neg <= i_exp_neg;
            r1_dropped <= i_dropped;
            r1_frac    <= i_frac;
        end
        if (w_adv2) begin
            r2_acc    <= r1_acc;
            r2_sticky <= r1_sticky;
            r2_e      <= w_e;
            r2_m      <= w_m;
            r2_zero   <= (r1_acc == '0);
        end
        if (w_adv3) begin
            r3_acc    <= r2_acc;
            r3_sticky <= r2_sticky;
            r3_s      <= w_s;
            r3_ue     <= w_ue;
            r3_sub    <= w_sub;
            r3_ovf    <= (w_ue > L_MAX_EXP);
            r3_zero   <= r2_zero;
        end
        if (w_adv4) begin
            r4_kept <= w_kept;
            r4_rbit <= w_rbit;
            r4_st   <= w_st;
            r4_ue   <= r3_ue;
            r4_sub  <= r3_sub;
            r4_ovf  <= r3_ovf;
            r4_zero <= r3_zero;
        end
        if (w_adv5) begin
            r5_req <= w_res;
        end
    end

    assign o_valid = r5_valid;
    assign o_req   = r5_req;

endmodule

`default_nettype wire

>>> design/hflp_checker.sv
// Port-level checks for the hex float literal parser, bound to its top level.
`default_nettype none

module hflp_checker
    import hflp_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_in_valid,
    input wire logic     o_in_ready,
    input wire t_in_req  i_in_req,
    input wire logic     o_out_valid,
    input wire logic     i_out_ready,
    input wire t_out_req o_out_req
);

    // Last characters taken whose results are not yet delivered.
    logic [3:0] r_pending;
    logic       w_in_last;
    logic       w_out_take;

    assign w_in_last  = i_in_valid && o_in_ready && i_in_req.is_last;
    assign w_out_take = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 4'(w_in_last) - 4'(w_out_take);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_req))
        else $error("result dropped or changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 4'd0)
        else $error("result without a pending last character");

    a_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_req.overflowed == (o_out_req.float_bits == INF_BITS))
        else $error("overflow flag disagrees with infinity encoding");

    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_out_req.float_bits[31])
        else $error("negative result");

endmodule

bind hex_float_literal_parser_top hflp_checker u_hflp_checker (.*);

`default_nettype wire
